// ----- rtl/efm_pkg.sv -----
package efm_pkg;

  localparam int unsigned SeWidth   = 16;
  localparam int unsigned ManWidth  = 64;
  localparam int unsigned HalfWidth = 32;
  localparam int unsigned ProdWidth = 128;
  localparam int unsigned ExpWidth  = 15;
  localparam int unsigned InDataWidth  = 160;
  localparam int unsigned OutDataWidth = 80;
  localparam int unsigned OutUserWidth = 2;

  localparam logic [SeWidth-1:0] SignBit = 16'h8000;
  localparam logic [ExpWidth-1:0] ExpMask = 15'h7fff;
  localparam int unsigned ExpBias = 16383;

  // exponent after bias, wide enough for the signed range
  typedef logic signed [17:0] exp_t;

endpackage

// ----- rtl/extended_float_multiply.sv -----
// Throughput: one transaction per cycle unless stalled; four 32x32 partial products in
//   stage 1, their sum over two stages, then leading-zero count, shift and packing.
// A stall holds the whole pipeline while the output register is full and not drained
//   and the last stage is valid; in_tready follows whether the pipeline moves.
// Reset (rst_n low, synchronous) clears all valid bits; data is not reset.
module extended_float_multiply (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // a_sign_exp[15:0], a_mantissa[79:16], b_sign_exp[95:80], b_mantissa[159:96]
  input  logic [159:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // product_sign_exp[15:0], product_mantissa[79:16]
  output logic [79:0]  out_tdata,
  // overflow_flag[0], product_written[1]
  output logic [1:0]   out_tuser
);
  import efm_pkg::*;

  localparam int unsigned NStage = 7;

  // per stage valid bits
  logic [NStage-1:0] v_r;
  logic              adv;
  logic              sk_ld;

  // stage registers
  logic [15:0]  sign0_r, sign1_r, sign2_r, sign3_r, sign4_r, sign5_r;
  exp_t         e0_r, e1_r, e2_r, e3_r, e4_r, e5_r;
  logic [63:0]  ma0_r, mb0_r;
  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic [64:0]  mid_r;
  logic [63:0]  lo2_r;
  logic [63:0]  hi2_r;
  logic [127:0] prod3_r, prod4_r, prod5_r;
  logic [6:0]   lz4_r;
  logic [79:0]  res_r;
  logic [1:0]   usr_r;

  // output register
  logic         sk_v_r;
  logic [79:0]  sk_d_r;
  logic [1:0]   sk_u_r;

  // output register loads when empty or drained; pipeline moves into it
  // or past a bubble in the last stage
  assign sk_ld     = !sk_v_r || out_tready;
  assign adv       = !v_r[NStage-1] || sk_ld;
  assign in_tready = adv;

  // stage 0: unpack and exponent
  exp_t e_in;
  assign e_in = exp_t'({3'b0, in_tdata[14:0]}) + exp_t'({3'b0, in_tdata[94:80]})
                - exp_t'(ExpBias) + exp_t'(1);

  // stage 2 sum of middle terms
  logic [64:0] mid_nxt;
  assign mid_nxt = 65'(p00_r[63:32]) + 65'(p01_r[31:0]) + 65'(p10_r[31:0]);

  // stage 2 partial high word
  logic [63:0] hi2_nxt;
  assign hi2_nxt = p11_r + {32'b0, p01_r[63:32]} + {32'b0, p10_r[63:32]};

  // stage 3 high word
  logic [63:0] hi_nxt;
  assign hi_nxt = hi2_r + {31'b0, mid_r[64:32]};

  // stage 4 leading zero count
  logic [6:0] lz_nxt;
  always_comb begin
    lz_nxt = 7'd0;
    for (int i = 0; i < 128; i++) begin
      if (prod3_r[i]) lz_nxt = 7'(127 - i);
    end
  end

  // stage 4->5: shift amount limited by exponent
  logic [6:0] sh4;
  always_comb begin
    if (e4_r < exp_t'(lz4_r)) sh4 = e4_r[6:0];
    else sh4 = lz4_r;
  end

  // final result packing
  logic [79:0] res_nxt;
  logic [1:0]  usr_nxt;
  logic [127:0] nrm;
  exp_t ef;
  always_comb begin
    nrm = prod5_r;
    ef  = e5_r;
    if (e5_r < 0) begin
      res_nxt = {64'b0, sign5_r};
      usr_nxt = 2'b10;
    end else if (e5_r > exp_t'({3'b0, ExpMask})) begin
      res_nxt = '0;
      usr_nxt = 2'b01;
    end else begin
      res_nxt = {nrm[127:64], sign5_r | {1'b0, ef[14:0]}};
      usr_nxt = 2'b10;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NStage-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sign0_r <= (in_tdata[15:0] ^ in_tdata[95:80]) & SignBit;
      e0_r    <= e_in;
      ma0_r   <= in_tdata[79:16];
      mb0_r   <= in_tdata[159:96];
      // stage 1: partial products
      sign1_r <= sign0_r;
      e1_r    <= e0_r;
      p00_r   <= ma0_r[31:0]  * mb0_r[31:0];
      p01_r   <= ma0_r[31:0]  * mb0_r[63:32];
      p10_r   <= ma0_r[63:32] * mb0_r[31:0];
      p11_r   <= ma0_r[63:32] * mb0_r[63:32];
      // stage 2: middle sum and partial high word
      sign2_r <= sign1_r;
      e2_r    <= e1_r;
      mid_r   <= mid_nxt;
      lo2_r   <= {mid_nxt[31:0], p00_r[31:0]};
      hi2_r   <= hi2_nxt;
      // stage 3: high word
      sign3_r <= sign2_r;
      e3_r    <= e2_r;
      prod3_r <= {hi_nxt, lo2_r};
      // stage 4: count zeros; zero product with in-range exponent forces exponent 0
      sign4_r <= sign3_r;
      prod4_r <= prod3_r;
      lz4_r   <= lz_nxt;
      if (prod3_r == '0 && e3_r >= 0 && e3_r <= exp_t'({3'b0, ExpMask})) e4_r <= '0;
      else e4_r <= e3_r;
      // stage 5: shift (non-negative, in-range exponents only matter)
      sign5_r <= sign4_r;
      if (e4_r >= 0 && e4_r <= exp_t'({3'b0, ExpMask})) begin
        prod5_r <= prod4_r << sh4;
        e5_r    <= e4_r - exp_t'(sh4);
      end else begin
        prod5_r <= prod4_r;
        e5_r    <= e4_r;
      end
      // stage 6: result
      res_r <= res_nxt;
      usr_r <= usr_nxt;
    end
  end

  // output register: load the last stage when empty or drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sk_v_r <= 1'b0;
    end else if (sk_ld) begin
      sk_v_r <= v_r[NStage-1];
    end
  end

  always_ff @(posedge clk) begin
    if (sk_ld) begin
      sk_d_r <= res_r;
      sk_u_r <= usr_r;
    end
  end

  assign out_tvalid = sk_v_r;
  assign out_tdata  = sk_d_r;
  assign out_tuser  = sk_u_r;

`ifndef SYNTH
  // a held result never changes while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata));
  // overflow and written are exclusive
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] ^ out_tuser[1]));
  // overflow result is all zero
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0);
`endif

endmodule
